FILE: sv/mfpq_pkg.sv
// Shared types and constants for the multilevel FIFO priority queue.
// Depends on nothing; every other file but mfpq_ram imports it.
`default_nettype none
package mfpq_pkg;

    localparam int LEVELS_DEF     = 8;
    localparam int FIFO_DEPTH_DEF = 16;

    localparam int ID_W   = 64;
    localparam int LVL_W  = 3;
    localparam int CNT_W  = 8;
    localparam int CFG_W  = 4;
    localparam int ST_W   = 2;
    localparam int OP_W   = 1;

    localparam int IN_TDATA_W  = 72;   // level, task id, pad
    localparam int OUT_TDATA_W = 80;   // task, level, count, pad

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

endpackage
`default_nettype wire

FILE: sv/mfpq_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module mfpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

FILE: sv/mfpq_scan.sv
// Level scan unit: lowest non-empty level in [hint, active levels).
// Depends on mfpq_pkg.
`default_nettype none
module mfpq_scan #(
    parameter int LEVELS = mfpq_pkg::LEVELS_DEF,
    parameter int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1,
    parameter int HW     = $clog2(LEVELS + 1)
) (
    input  wire logic [LEVELS-1:0] i_nonempty,
    input  wire logic [HW-1:0]     i_hint,
    input  wire logic [HW-1:0]     i_active,
    output logic                   o_found,
    output logic      [LW-1:0]     o_idx
);
    import mfpq_pkg::*;

    logic [LEVELS-1:0] w_cand;

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            w_cand[i] = i_nonempty[i] && (i >= 32'(i_hint)) && (i < 32'(i_active));
        end
    end

    always_comb begin
        o_idx = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                o_idx = LW'(i);
            end
        end
    end

    assign o_found = |w_cand;

endmodule
`default_nettype wire

FILE: sv/multilevel_fifo_priority_queue_unit.sv
// Multilevel FIFO priority queue: sequencer, per-level pointers, shared task RAM.
// Depends on mfpq_pkg, mfpq_scan, mfpq_ram.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: opcode; tdata: level, task id
//  m_axis    out  m_axis_tvalid/tready       tuser: status; tdata: task, level, count
//  cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_data: levels in use
//
// An item passes the lookup state, which scans levels and accesses the task RAM, then
// the finish state, in which the registered RAM read data reaches the output register.
// The next request is taken in the cycle the result is loaded into the output register.
// A stalled output holds the sequencer in its final state; input ready stays low.
// Reset clears all levels at once; no clearing pass is needed.
`default_nettype none
module multilevel_fifo_priority_queue_unit #(
    parameter int LEVELS     = mfpq_pkg::LEVELS_DEF,
    parameter int FIFO_DEPTH = mfpq_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [2:0] priority_level, [66:3] task_id, [71:67] zero
    input  wire logic [mfpq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] opcode
    input  wire logic [mfpq_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [63:0] task_out, [66:64] level_out, [74:67] total_count, [79:75] zero
    output logic      [mfpq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic      [mfpq_pkg::ST_W-1:0]         m_axis_tuser,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [mfpq_pkg::CFG_W-1:0]        i_cfg_data
);
    import mfpq_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int HW = $clog2(LEVELS + 1);
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int OW = $clog2(FIFO_DEPTH + 1);
    localparam int DEPTH = LEVELS * FIFO_DEPTH;
    localparam int AW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_cfg;
    logic [HW-1:0]    r_hint;
    logic [CNT_W-1:0] r_total;
    logic [PW-1:0]    r_head [LEVELS];
    logic [PW-1:0]    r_tail [LEVELS];
    logic [OW-1:0]    r_occ  [LEVELS];

    logic [OP_W-1:0]  r_op;
    logic [LVL_W-1:0] r_lvl;
    logic [ID_W-1:0]  r_id;
    logic [ST_W-1:0]  r_status;
    logic             r_hit;
    logic [LVL_W-1:0] r_lout;
    logic [AW-1:0]    r_addr;

    logic              r_mvalid;
    logic [ST_W-1:0]   r_mstatus;
    logic [ID_W-1:0]   r_mtask;
    logic [LVL_W-1:0]  r_mlvl;
    logic [CNT_W-1:0]  r_mcount;

    logic              w_accept, w_out_free, w_load;
    logic [HW-1:0]     w_active;
    logic [LEVELS-1:0] w_nonempty;
    logic              w_found;
    logic [LW-1:0]     w_scan_idx, w_idx;
    logic              w_range_bad, w_full, w_do_write, w_do_read;
    logic [PW-1:0]     w_ptr, w_ptr_next;
    logic [AW-1:0]     w_addr, w_ram_addr;
    logic [ID_W-1:0]   w_rdata;

    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_mvalid || m_axis_tready;
    assign w_load        = (r_state == S_FIN) && w_out_free;
    assign s_axis_tready = (r_state == S_IDLE) || w_load;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_active = (32'(r_cfg) > LEVELS) ? HW'(LEVELS) : HW'(r_cfg);

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            w_nonempty[i] = (r_occ[i] != '0);
        end
    end

    mfpq_scan #(
        .LEVELS (LEVELS),
        .LW     (LW),
        .HW     (HW)
    ) u_scan (
        .i_nonempty (w_nonempty),
        .i_hint     (r_hint),
        .i_active   (w_active),
        .o_found    (w_found),
        .o_idx      (w_scan_idx)
    );

    assign w_range_bad = (32'(r_lvl) >= 32'(w_active));
    assign w_idx       = (r_op == OP_INSERT) ? LW'(r_lvl) : w_scan_idx;
    assign w_full      = !w_range_bad && (32'(r_occ[w_idx]) >= FIFO_DEPTH);
    assign w_do_write  = (r_state == S_LOOK) && (r_op == OP_INSERT) && !w_range_bad && !w_full;
    assign w_do_read   = (r_state == S_LOOK) && (r_op == OP_REMOVE) && w_found;
    assign w_ptr       = (r_op == OP_INSERT) ? r_tail[w_idx] : r_head[w_idx];
    assign w_ptr_next  = (w_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : w_ptr + PW'(1);
    assign w_addr      = AW'(32'(w_idx) * FIFO_DEPTH + 32'(w_ptr));
    assign w_ram_addr  = (r_state == S_FIN) ? r_addr : w_addr;

    mfpq_ram #(
        .WIDTH (ID_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_do_write),
        .i_addr  (w_ram_addr),
        .i_wdata (r_id),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_LOOK;
            S_LOOK:  n_state = S_FIN;
            S_FIN:   if (w_load) n_state = w_accept ? S_LOOK : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= CFG_RESET;
            r_hint   <= HW'(LEVELS);
            r_total  <= '0;
            r_mvalid <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_occ[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (w_do_write) begin
                r_tail[w_idx] <= w_ptr_next;
                r_occ[w_idx]  <= r_occ[w_idx] + OW'(1);
                r_total       <= r_total + CNT_W'(1);
                if (32'(r_lvl) < 32'(r_hint)) begin
                    r_hint <= HW'(r_lvl);
                end
            end
            if (w_do_read) begin
                r_head[w_idx] <= w_ptr_next;
                r_occ[w_idx]  <= r_occ[w_idx] - OW'(1);
                r_total       <= r_total - CNT_W'(1);
                r_hint        <= HW'(w_scan_idx);
            end
            if (w_load) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= s_axis_tuser;
            r_lvl <= s_axis_tdata[LVL_W-1:0];
            r_id  <= s_axis_tdata[LVL_W +: ID_W];
        end
        if (r_state == S_LOOK) begin
            r_addr <= w_addr;
            r_hit  <= w_do_read;
            r_lout <= w_do_read ? LVL_W'(w_scan_idx) : '0;
            if (r_op == OP_INSERT) begin
                r_status <= w_range_bad ? ST_RANGE : (w_full ? ST_FULL : ST_OK);
            end else begin
                r_status <= w_found ? ST_OK : ST_EMPTY;
            end
        end
        if (w_load) begin
            r_mstatus <= r_status;
            r_mtask   <= r_hit ? w_rdata : '0;
            r_mlvl    <= r_lout;
            r_mcount  <= r_total;
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tuser  = r_mstatus;
    assign m_axis_tdata  = {{(OUT_TDATA_W - ID_W - LVL_W - CNT_W){1'b0}},
                            r_mcount, r_mlvl, r_mtask};

    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOOK))
        else $error("request accepted without entering lookup");

    a_look_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state == S_FIN))
        else $error("lookup not followed by finish");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |->
        ((m_axis_tdata[ID_W-1:0] == '0) && (m_axis_tdata[ID_W +: LVL_W] == '0)))
        else $error("failed request carries a task");

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hint) <= LEVELS)
        else $error("start hint beyond level count");

    a_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_do_write && w_do_read))
        else $error("insert and remove in one lookup");

endmodule
`default_nettype wire

FILE: tb/mfpq_checker.sv
// Checker for the multilevel FIFO priority queue: watches the request, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on mfpq_pkg.
`timescale 1ns / 100ps
module mfpq_checker #(
    parameter int LEVELS     = mfpq_pkg::LEVELS_DEF,
    parameter int FIFO_DEPTH = mfpq_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              i_s_tready,
    // [2:0] priority_level, [66:3] task_id, [71:67] zero
    input  wire logic [mfpq_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [0] opcode
    input  wire logic [mfpq_pkg::OP_W-1:0]         i_s_tuser,
    input  wire logic                              i_m_tvalid,
    input  wire logic                              i_m_tready,
    // [63:0] task_out, [66:64] level_out, [74:67] total_count, [79:75] zero
    input  wire logic [mfpq_pkg::OUT_TDATA_W-1:0]  i_m_tdata,
    // [1:0] status
    input  wire logic [mfpq_pkg::ST_W-1:0]         i_m_tuser,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              i_cfg_ready,
    input  wire logic [mfpq_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import mfpq_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  task_id;
        logic [LVL_W-1:0] level;
        logic [CNT_W-1:0] count;
    } queue_result_t;

    queue_result_t     predicted_results[$];

    logic [ID_W-1:0]   task_ram [LEVELS][FIFO_DEPTH];
    int                head_slot [LEVELS];
    int                tail_slot [LEVELS];
    int                level_fill [LEVELS];
    int                start_level;
    int                tasks_held;
    logic [CFG_W-1:0]  levels_in_use;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                   input logic [ID_W-1:0] want);
        $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic apply_request(input logic [OP_W-1:0] op, input logic [LVL_W-1:0] lvl,
                                 input logic [ID_W-1:0] id);
        queue_result_t r;
        int            active;
        int            scan;
        bit            found;
        r        = '0;
        r.status = ST_OK;
        found    = 1'b0;
        active   = (levels_in_use > LEVELS) ? LEVELS : int'(levels_in_use);
        if (op == OP_INSERT) begin
            if (int'(lvl) >= active) begin
                r.status = ST_RANGE;
            end else if (level_fill[lvl] >= FIFO_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                task_ram[lvl][tail_slot[lvl]] = id;
                tail_slot[lvl] = (tail_slot[lvl] + 1) % FIFO_DEPTH;
                level_fill[lvl]++;
                tasks_held++;
                if (int'(lvl) < start_level)
                    start_level = int'(lvl);
            end
        end else begin
            for (scan = start_level; scan < active && !found; scan++) begin
                if (level_fill[scan] != 0) begin
                    r.task_id = task_ram[scan][head_slot[scan]];
                    r.level   = scan[LVL_W-1:0];
                    head_slot[scan] = (head_slot[scan] + 1) % FIFO_DEPTH;
                    level_fill[scan]--;
                    tasks_held--;
                    start_level = scan;
                    found = 1'b1;
                end
            end
            if (!found)
                r.status = ST_EMPTY;
        end
        r.count = tasks_held[CNT_W-1:0];
        predicted_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        queue_result_t want;
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                head_slot[l]  = 0;
                tail_slot[l]  = 0;
                level_fill[l] = 0;
            end
            start_level   = LEVELS;
            tasks_held    = 0;
            levels_in_use = CFG_RESET;
            predicted_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                levels_in_use = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with no request pending", i_m_tdata[63:0], '0);
                end else begin
                    want = predicted_results.pop_front();
                    if (i_m_tuser !== want.status)
                        report_mismatch("status", ID_W'(i_m_tuser), ID_W'(want.status));
                    if (i_m_tdata[63:0] !== want.task_id)
                        report_mismatch("task_out", i_m_tdata[63:0], want.task_id);
                    if (i_m_tdata[66:64] !== want.level)
                        report_mismatch("level_out", ID_W'(i_m_tdata[66:64]),
                                        ID_W'(want.level));
                    if (i_m_tdata[74:67] !== want.count)
                        report_mismatch("total_count", ID_W'(i_m_tdata[74:67]),
                                        ID_W'(want.count));
                end
            end
            if (i_s_tvalid && i_s_tready)
                apply_request(i_s_tuser, i_s_tdata[2:0], i_s_tdata[66:3]);
        end
        o_pending = predicted_results.size();
    end

endmodule

FILE: tb/tb_multilevel_fifo_priority_queue_unit.sv
// Testbench top for the multilevel FIFO priority queue: clock, reset, request and
// configuration stimulus, result back-pressure and the verdict.
// Depends on mfpq_pkg, mfpq_checker and the multilevel_fifo_priority_queue_unit RTL.
`timescale 1ns / 100ps
module tb_multilevel_fifo_priority_queue_unit;
    import mfpq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]         s_tuser = OP_INSERT;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [ST_W-1:0]         m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data = CFG_RESET;

    int                      fail_count;
    int                      pending;
    int                      cycles = 0;
    int                      requests_sent = 0;
    int                      hold_left = 0;
    bit                      hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    multilevel_fifo_priority_queue_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    mfpq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("multilevel_fifo_priority_queue_unit verification failed");
            $finish;
        end
    end

    // Result side: random back-pressure, one long hold while the queue fills.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!hold_done && requests_sent >= 420) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (requests_sent >= 700 && requests_sent < 900) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 22);
            end
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [LVL_W-1:0] lvl,
                                input logic [ID_W-1:0] id);
        bit steady;
        steady = (requests_sent >= 700 && requests_sent < 850);
        while (!steady && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, id, lvl};
        do @(posedge i_clk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_levels(input logic [CFG_W-1:0] value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int insert_pct, input int active);
        logic [OP_W-1:0]  op;
        logic [LVL_W-1:0] lvl;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            if (active > 0 && $urandom_range(9) != 0)
                lvl = LVL_W'($urandom_range(active - 1));
            else
                lvl = LVL_W'($urandom_range(7));
            send_request(op, lvl, {$urandom, $urandom});
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all levels active after reset
        send_request(OP_REMOVE, 3'd0, '0);
        send_request(OP_INSERT, 3'd0, '1);
        send_request(OP_INSERT, 3'd7, '0);
        send_request(OP_INSERT, 3'd3, {$urandom, $urandom});
        send_request(OP_REMOVE, 3'd5, '1);
        send_request(OP_REMOVE, 3'd0, '0);
        send_request(OP_REMOVE, 3'd7, {$urandom, $urandom});
        send_request(OP_REMOVE, 3'd0, '0);

        write_levels(4'd1);
        send_request(OP_INSERT, 3'd1, {$urandom, $urandom});
        send_request(OP_INSERT, 3'd0, 64'h0123_4567_89ab_cdef);
        send_request(OP_INSERT, 3'd7, '1);
        send_request(OP_REMOVE, 3'd0, '0);

        write_levels(4'd0);
        send_request(OP_INSERT, 3'd0, {$urandom, $urandom});
        send_request(OP_REMOVE, 3'd0, '0);

        // tasks parked above the active range after shrinking
        write_levels(4'd8);
        send_request(OP_INSERT, 3'd5, {$urandom, $urandom});
        send_request(OP_INSERT, 3'd6, {$urandom, $urandom});
        write_levels(4'd3);
        send_request(OP_REMOVE, 3'd0, '0);
        send_request(OP_INSERT, 3'd4, {$urandom, $urandom});
        write_levels(4'd15);
        send_request(OP_REMOVE, 3'd0, '0);
        send_request(OP_REMOVE, 3'd0, '0);

        write_levels(4'd2);
        run_random(150, 75, 2);
        run_random(100, 25, 2);

        write_levels(4'd8);
        run_random(300, 80, 8);
        wait_drain();
        run_random(200, 20, 8);

        write_levels(4'd5);
        run_random(200, 50, 5);

        write_levels(4'd15);
        run_random(150, 50, 8);

        write_levels(4'd1);
        run_random(50, 50, 1);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("multilevel_fifo_priority_queue_unit verification clean");
        else
            $display("multilevel_fifo_priority_queue_unit verification failed");
        $finish;
    end

endmodule
